// ----- src/sidta_pkg.sv -----
`timescale 1ns / 1ps
package sidta_pkg;

    localparam int VALUE_W       = 32;
    localparam int CFG_W         = 4;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 10;
    localparam int BITS_PER_STEP = 4;
    localparam int STEP_COUNT    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEP_COUNT);
    localparam int POS_W         = $clog2(NUM_DIGITS);

    localparam logic [CFG_W-1:0]  DIGIT_COUNT_RESET = CFG_W'(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;
    typedef logic [BITS_PER_STEP-1:0] carry_t;

    typedef struct packed {
        logic clr;
        logic step;
    } cell_ctl_t;

    typedef struct packed {
        logic              neg;
        logic [POS_W-1:0]  top;
        digit_vec_t        digits;
    } ser_item_t;

    // double-dabble correction ahead of each shift
    function automatic digit_t add3(input digit_t d);
        return (d >= digit_t'(5)) ? digit_t'(d + digit_t'(3)) : d;
    endfunction

    // index of the most significant emitted digit, count clamped to 1..10
    function automatic logic [POS_W-1:0] top_index(input logic [CFG_W-1:0] c);
        logic [POS_W-1:0] r;
        if (c == '0) begin
            r = '0;
        end else if (c > CFG_W'(NUM_DIGITS)) begin
            r = POS_W'(NUM_DIGITS - 1);
        end else begin
            r = POS_W'(c - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

// ----- src/sidta_bcd_cell.sv -----
`timescale 1ns / 1ps
module sidta_bcd_cell import sidta_pkg::*; (
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  carry_t    carry_in,
    output carry_t    carry_out,
    output digit_t    digit
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t stage_v [BITS_PER_STEP+1];
    digit_t adj_v   [BITS_PER_STEP];

    // carry_in[0] is shifted in first
    always_comb begin
        stage_v[0] = digit_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            adj_v[s]       = add3(stage_v[s]);
            carry_out[s]   = adj_v[s][DIGIT_W-1];
            stage_v[s+1]   = {adj_v[s][DIGIT_W-2:0], carry_in[s]};
        end
    end

    always_comb begin
        digit_next = digit_reg;
        if (ctl.clr) begin
            digit_next = '0;
        end else if (ctl.step) begin
            digit_next = stage_v[BITS_PER_STEP];
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

// ----- src/sidta_serializer.sv -----
`timescale 1ns / 1ps
module sidta_serializer import sidta_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  ser_item_t         load_item,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_character,
    output logic              m_last
);

    logic             valid_reg, valid_next;
    logic             sign_phase_reg, sign_phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             neg_reg, neg_next;
    digit_vec_t       digits_reg, digits_next;

    logic beat;
    logic final_digit;

    assign final_digit = !sign_phase_reg && (pos_reg == '0);
    assign beat        = valid_reg && m_ready;
    assign can_load    = !valid_reg || (beat && final_digit);

    always_comb begin
        valid_next      = valid_reg;
        sign_phase_next = sign_phase_reg;
        pos_next        = pos_reg;
        neg_next        = neg_reg;
        digits_next     = digits_reg;
        if (load) begin
            valid_next      = 1'b1;
            sign_phase_next = 1'b1;
            pos_next        = load_item.top;
            neg_next        = load_item.neg;
            digits_next     = load_item.digits;
        end else if (beat) begin
            if (sign_phase_reg) begin
                sign_phase_next = 1'b0;
            end else if (pos_reg == '0) begin
                valid_next = 1'b0;
            end else begin
                pos_next = pos_reg - POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            sign_phase_reg <= 1'b1;
        end else begin
            valid_reg      <= valid_next;
            sign_phase_reg <= sign_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        neg_reg    <= neg_next;
        digits_reg <= digits_next;
    end

    always_comb begin
        if (sign_phase_reg) begin
            m_character = neg_reg ? CH_MINUS : CH_SPACE;
        end else begin
            m_character = CH_ZERO + CHAR_W'(digits_reg[pos_reg]);
        end
    end

    assign m_valid = valid_reg;
    assign m_last  = final_digit;

endmodule

// ----- src/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// Converts a signed 32-bit value into a sign character ('-' or space) followed by
// digit_count ASCII digits, most significant first, one character per output beat,
// with m_last on the final digit. Digit counts of 0 act as 1 and above 10 act as 10;
// fewer than ten digits keep only the low-order ones. The magnitude is converted by
// a chain of ten BCD digit cells doing double-dabble, four input bits per cycle; the
// conversion overlaps with the output of the previous value. A new value is taken
// while the converter is idle, or as its finished result is loaded into the
// serializer, which happens once the previous value's last digit goes out.
module signed_int_to_decimal_ascii import sidta_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CHAR_W-1:0]         m_character,
    output logic                      m_last
);

    typedef enum logic [2:0] {
        CV_IDLE = 3'b001,
        CV_RUN  = 3'b010,
        CV_DONE = 3'b100
    } cv_state_t;

    cv_state_t            cv_state_reg, cv_state_next;
    logic [CFG_W-1:0]     digit_count_reg;
    logic [STEP_W-1:0]    step_cnt_reg, step_cnt_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic                 neg_reg, neg_next;

    logic [VALUE_W-1:0]   value_u;
    logic [VALUE_W-1:0]   mag_in;
    logic                 s_accept;
    logic                 ser_can_load;
    logic                 ser_load;
    ser_item_t            ser_item;
    cell_ctl_t            cell_ctl;
    carry_t               feed;
    carry_t               cell_in  [NUM_DIGITS];
    carry_t               carry    [NUM_DIGITS];
    digit_t               digits   [NUM_DIGITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= DIGIT_COUNT_RESET;
        end else if (cfg_wr_en) begin
            digit_count_reg <= cfg_wr_data;
        end
    end

    assign value_u  = s_value;
    assign mag_in   = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;

    assign ser_load = (cv_state_reg == CV_DONE) && ser_can_load;
    assign s_ready  = (cv_state_reg == CV_IDLE) || ser_load;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        cv_state_next = cv_state_reg;
        step_cnt_next = step_cnt_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        unique case (cv_state_reg)
            CV_IDLE: begin
                if (s_accept) begin
                    cv_state_next = CV_RUN;
                end
            end
            CV_RUN: begin
                step_cnt_next = step_cnt_reg + STEP_W'(1);
                mag_next      = mag_reg << BITS_PER_STEP;
                if (step_cnt_reg == STEP_W'(STEP_COUNT - 1)) begin
                    cv_state_next = CV_DONE;
                end
            end
            CV_DONE: begin
                if (ser_load) begin
                    cv_state_next = s_accept ? CV_RUN : CV_IDLE;
                end
            end
            default: begin
                cv_state_next = CV_IDLE;
            end
        endcase
        if (s_accept) begin
            step_cnt_next = '0;
            mag_next      = mag_in;
            neg_next      = value_u[VALUE_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_state_reg <= CV_IDLE;
            step_cnt_reg <= '0;
        end else begin
            cv_state_reg <= cv_state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    assign cell_ctl.clr  = s_accept;
    assign cell_ctl.step = (cv_state_reg == CV_RUN);

    // magnitude enters the least significant cell msb first
    always_comb begin
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            feed[s] = mag_reg[VALUE_W-1-s];
        end
    end

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign cell_in[i] = feed;
        end else begin : g_next
            assign cell_in[i] = carry[i-1];
        end
        sidta_bcd_cell u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl),
            .carry_in  (cell_in[i]),
            .carry_out (carry[i]),
            .digit     (digits[i])
        );
        assign ser_item.digits[i] = digits[i];
    end

    assign ser_item.neg = neg_reg;
    assign ser_item.top = top_index(digit_count_reg);

    sidta_serializer u_ser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (ser_load),
        .load_item   (ser_item),
        .can_load    (ser_can_load),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    // the top digit never spills out, since every magnitude is below 10^10
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cv_state_reg == CV_RUN) |-> (carry[NUM_DIGITS-1] == '0))
        else $error("bcd chain overflow");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cv_state_reg == CV_RUN && step_cnt_reg == '0))
        else $error("conversion did not start after input beat");

    a_sign_first: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_load |=> (m_valid && !m_last
                      && (m_character == CH_MINUS || m_character == CH_SPACE)))
        else $error("value does not open with a sign character");

    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_character >= CH_ZERO && m_character <= CH_NINE))
        else $error("last flag on a non-digit character");

endmodule

// ----- bench/signed_int_to_decimal_ascii_tb.sv -----
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_tb;
    import sidta_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DECIMAL_BASE   = 10;
    localparam int RANDOM_PHASES  = 12;
    localparam int VALUES_PER_PHASE = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]          cfg_wr_data = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value     = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic [CHAR_W-1:0]         m_character;
    logic                      m_last;

    char_beat_t       text_q[$];
    logic [CFG_W-1:0] digit_setting = DIGIT_COUNT_RESET;
    int               errors        = 0;
    int               cycles        = 0;
    int               burst_left    = 0;
    int               stall_mode    = 0;
    int               stall_timer   = 0;

    signed_int_to_decimal_ascii dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_character(m_character),
        .m_last     (m_last)
    );

    always #CLK_HALF aclk = ~aclk;

    // queue up the sign character and the digit characters for one value
    function automatic void predict_text(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag32;
        longint unsigned    mag;
        longint unsigned    scale;
        int                 n;
        int                 k;
        char_beat_t         b;
        mag32 = v[VALUE_W-1] ? (32'd0 - v) : v;
        mag   = {32'd0, mag32};
        if (digit_setting == '0) begin
            n = 1;
        end else if (digit_setting > NUM_DIGITS) begin
            n = NUM_DIGITS;
        end else begin
            n = int'(digit_setting);
        end
        scale = 1;
        for (k = 0; k < n; k++) begin
            scale = scale * DECIMAL_BASE;
        end
        mag    = mag % scale;
        b.ch   = v[VALUE_W-1] ? CH_MINUS : CH_SPACE;
        b.last = 1'b0;
        text_q.push_back(b);
        for (k = 0; k < n; k++) begin
            scale  = scale / DECIMAL_BASE;
            b.ch   = CH_ZERO + CHAR_W'((mag / scale) % DECIMAL_BASE);
            b.last = (k == n - 1);
            text_q.push_back(b);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] p;
        int                 k;
        logic [VALUE_W-1:0] v;
        v = '0;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: begin
                v = $urandom_range(0, 999);
                if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
            end
            3: begin
                // straddle a power of ten
                p = 1;
                for (k = $urandom_range(0, 9); k > 0; k--) begin
                    p = p * DECIMAL_BASE;
                end
                v = p + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
            end
            4: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h8000_0001;
                endcase
            end
            default: v = 32'd0 - $urandom;
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        predict_text(v);
        burst_left--;
    endtask

    task automatic settle_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (text_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_digit_count(input logic [CFG_W-1:0] c);
        settle_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        digit_setting = c;
    endtask

    // runs on the reset digit count
    task automatic test_sign_and_extremes();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1000000000);
        send_value(32'd0 - 32'd1000000000);
        send_value(32'd999999999);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
        send_value(32'd0 - 32'd10);
    endtask

    task automatic test_digit_count_limits();
        // zero digits acts as one
        write_digit_count(4'd0);
        send_value(32'd7);
        send_value(32'h8000_0000);
        write_digit_count(4'd1);
        send_value(32'd19);
        send_value(32'd0 - 32'd5);
        // counts above ten saturate
        write_digit_count(4'd15);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        write_digit_count(4'd11);
        send_value(32'd1234567890);
        write_digit_count(4'd2);
        send_value(32'd0 - 32'd100);
        send_value(32'd99);
        write_digit_count(4'd10);
        send_value(32'd0);
    endtask

    task automatic test_random_values();
        int                phase;
        int                i;
        logic [CFG_W-1:0]  c;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: c = 4'd10;
                1: c = 4'd1;
                2: c = 4'd0;
                3: c = 4'd15;
                default: c = $urandom_range(0, 15);
            endcase
            write_digit_count(c);
            for (i = 0; i < VALUES_PER_PHASE; i++) begin
                send_value(pick_value());
            end
        end
    endtask

    // receiver ready pattern, switching style every so often
    always @(negedge aclk) begin
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 120);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 2) == 0);
            default: m_ready <= ((cycles % 7) < 4);
        endcase
    end

    always @(posedge aclk) begin
        char_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (text_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got char %h last %b",
                         $time, m_character, m_last);
                errors++;
            end else begin
                want = text_q.pop_front();
                if (m_character !== want.ch || m_last !== want.last) begin
                    $display("%0t: expected char %h last %b, got char %h last %b",
                             $time, want.ch, want.last, m_character, m_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_sign_and_extremes();
        test_digit_count_limits();
        test_random_values();
        settle_idle();
        if (errors == 0 && text_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- signed_int_to_decimal_ascii.f -----
src/sidta_pkg.sv
src/sidta_bcd_cell.sv
src/sidta_serializer.sv
src/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_tb.sv
